// ===== src/icbr_pkg.sv =====
// package: beat types, register indexes and saturating helpers for the bisection root finder
package icbr_pkg;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 6;
    localparam int TOL_W   = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd2;

    localparam logic signed [COORD_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] low_x;
        logic signed [COORD_W-1:0] low_y;
        logic signed [COORD_W-1:0] high_x;
        logic signed [COORD_W-1:0] high_y;
        logic                      last_edge;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] root_x;
        logic signed [COORD_W-1:0] root_y;
        logic                      converged;
        logic [STEP_W-1:0]         steps_taken;
        logic                      batch_end;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MID,
        ST_WAIT
    } state_t;

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1])
            return s[COORD_W] ? S_MIN : S_MAX;
        return s[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_sub(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1])
            return s[COORD_W] ? S_MIN : S_MAX;
        return s[COORD_W-1:0];
    endfunction

endpackage

// ===== src/implicit_curve_bisection_root.sv =====
// top level: bisection root finder for implicit curves, controller and registers
//
// One edge beat is taken when start is high and busy is low; busy then stays
// high until the result beat. Each bisection step forms the midpoint
// combinationally in ST_MID and runs it through a five-stage evaluation
// chain built from multiply cells, waiting in ST_WAIT for its value. The
// result is presented on result with done high for exactly one cycle; there
// is no back-pressure, so the receiver must take it then. A new edge may be
// started in the cycle done is high. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be issued while busy is low.
module implicit_curve_bisection_root #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  icbr_pkg::item_t                      item,
    output logic                                 done,
    output icbr_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [icbr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [icbr_pkg::COORD_W-1:0]         cfg_data
);
    import icbr_pkg::*;

    state_t state_reg, state_next;

    // configuration registers
    logic             kind_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [STEP_W-1:0] limit_reg;

    // segment ends and current midpoint
    logic signed [COORD_W-1:0] lx_reg, ly_reg, hx_reg, hy_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic signed [COORD_W-1:0] cx_next, cy_next;
    logic [STEP_W-1:0]         steps_reg;
    logic                      last_reg;

    logic    done_reg;
    result_t result_reg;

    // controller outputs
    logic launch;
    logic accept;

    logic                      ev_valid;
    logic signed [COORD_W-1:0] ev_value;
    logic [COORD_W-1:0]        abs_v;
    logic                      hit;
    logic                      finish;

    logic signed [COORD_W:0] sum_x, sum_y;

    assign accept = start && (state_reg == ST_IDLE);

    // midpoint, flooring shift
    always_comb
    begin
        sum_x   = {lx_reg[COORD_W-1], lx_reg} + {hx_reg[COORD_W-1], hx_reg};
        sum_y   = {ly_reg[COORD_W-1], ly_reg} + {hy_reg[COORD_W-1], hy_reg};
        cx_next = sum_x[COORD_W:1];
        cy_next = sum_y[COORD_W:1];
    end

    // tolerance test and stop decision
    always_comb
    begin
        abs_v  = ev_value[COORD_W-1] ? (~ev_value + 1'b1) : ev_value;
        hit    = abs_v < {1'b0, tol_reg};
        finish = hit || (steps_reg == limit_reg);
    end

    icbr_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .curve_kind (kind_reg),
        .in_valid   (launch),
        .x          (cx_next),
        .y          (cy_next),
        .out_valid  (ev_valid),
        .value      (ev_value)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_MID;
            ST_MID:  state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (ev_valid)
                    state_next = finish ? ST_IDLE : ST_MID;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        launch = 1'b0;
        unique case (state_reg)
            ST_IDLE: launch = 1'b0;
            ST_MID:  launch = 1'b1;
            ST_WAIT: launch = 1'b0;
            default: launch = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            steps_reg <= '0;
            kind_reg  <= 1'b0;
            tol_reg   <= 31'd17;
            limit_reg <= 6'd32;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WAIT) && ev_valid && finish;
            if (accept)
                steps_reg <= '0;
            else if ((state_reg == ST_WAIT) && ev_valid && !finish)
                steps_reg <= steps_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CURVE_KIND: kind_reg  <= cfg_data[0];
                    CFG_TOLERANCE:  tol_reg   <= cfg_data[TOL_W-1:0];
                    CFG_ITER_LIMIT: limit_reg <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lx_reg   <= item.low_x;
            ly_reg   <= item.low_y;
            hx_reg   <= item.high_x;
            hy_reg   <= item.high_y;
            last_reg <= item.last_edge;
        end
        else if ((state_reg == ST_WAIT) && ev_valid && !finish)
        begin
            // positive value pulls the high end in, otherwise the low end
            if (!ev_value[COORD_W-1] && (ev_value != '0))
            begin
                hx_reg <= cx_reg;
                hy_reg <= cy_reg;
            end
            else
            begin
                lx_reg <= cx_reg;
                ly_reg <= cy_reg;
            end
        end
        if (launch)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
        if ((state_reg == ST_WAIT) && ev_valid && finish)
        begin
            result_reg.root_x      <= cx_reg;
            result_reg.root_y      <= cy_reg;
            result_reg.converged   <= hit;
            result_reg.steps_taken <= steps_reg;
            result_reg.batch_end   <= last_reg;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // evaluation results only come back while a step is waiting for them
    a_eval_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (state_reg == ST_WAIT))
        else $error("evaluation result outside wait state");

    // a result beat always follows a wait state and leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_WAIT) && !busy)
        else $error("result beat while busy");

    // the step count never passes the limit during a search
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && (state_reg != ST_MID || steps_reg != '0)) |-> (steps_reg <= limit_reg))
        else $error("step count beyond limit");
endmodule

// ===== src/icbr_mul_cell.sv =====
// registered fixed point multiply cell with truncation and saturation
module icbr_mul_cell #(
    parameter int FRAC_BITS = 24
) (
    input  logic                             clk,
    input  logic signed [icbr_pkg::COORD_W-1:0] a,
    input  logic signed [icbr_pkg::COORD_W-1:0] b,
    output logic signed [icbr_pkg::COORD_W-1:0] p
);
    import icbr_pkg::*;

    logic signed [2*COORD_W-1:0] prod;
    logic signed [2*COORD_W-1:0] shifted;
    logic signed [COORD_W-1:0]   p_next;
    logic signed [COORD_W-1:0]   p_reg;

    always_comb
    begin
        prod    = a * b;
        shifted = prod >>> FRAC_BITS;
        // fits when the result sign and all bits above it agree
        if ((&shifted[2*COORD_W-1:COORD_W-1]) || !(|shifted[2*COORD_W-1:COORD_W-1]))
            p_next = shifted[COORD_W-1:0];
        else
            p_next = shifted[2*COORD_W-1] ? S_MIN : S_MAX;
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

// ===== src/icbr_eval.sv =====
// curve evaluation chain: a row of multiply cells, one stage per cycle
module icbr_eval #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                curve_kind,
    input  logic                                in_valid,
    input  logic signed [icbr_pkg::COORD_W-1:0] x,
    input  logic signed [icbr_pkg::COORD_W-1:0] y,
    output logic                                out_valid,
    output logic signed [icbr_pkg::COORD_W-1:0] value
);
    import icbr_pkg::*;

    localparam int LAT = 5;
    localparam logic signed [COORD_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    logic signed [COORD_W-1:0] x2, y2, xy2, tt3, q3, ttt4;
    logic signed [COORD_W-1:0] y1_reg, y2_reg;
    logic signed [COORD_W-1:0] t2_reg, t3_reg, t4_reg, q4_reg, v5_reg;

    // stage 1: squares
    icbr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell_xx (.clk(clk), .a(x), .b(x), .p(x2));
    icbr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell_yy (.clk(clk), .a(y), .b(y), .p(y2));
    // stage 2: x2*y2
    icbr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell_xy (.clk(clk), .a(x2), .b(y2), .p(xy2));
    // stage 3: t*t and x2*y2*y
    icbr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell_tt (.clk(clk), .a(t2_reg), .b(t2_reg),
                                                      .p(tt3));
    icbr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell_q (.clk(clk), .a(xy2), .b(y2_reg), .p(q3));
    // stage 4: t cubed
    icbr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell_ttt (.clk(clk), .a(tt3), .b(t3_reg),
                                                       .p(ttt4));

    assign valid_next = {valid_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        y1_reg <= y;
        y2_reg <= y1_reg;
        t2_reg <= sat_sub(sat_add(x2, y2), ONE);
        t3_reg <= t2_reg;
        t4_reg <= t3_reg;
        q4_reg <= q3;
        v5_reg <= curve_kind ? sat_sub(ttt4, q4_reg) : t4_reg;
    end

    assign out_valid = valid_reg[LAT-1];
    assign value     = v5_reg;
endmodule

// ===== tb/implicit_curve_bisection_root_test.sv =====
// testbench: random and directed edges through the bisection root finder, checked against a local model
`timescale 1ns / 100ps

module implicit_curve_bisection_root_test;
    import icbr_pkg::*;

    localparam int FRAC = 24;
    localparam longint ONE_FX = 64'sd1 << FRAC;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    item_t item;
    logic done;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_data;

    implicit_curve_bisection_root #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // local copy of the configuration registers
    logic        mdl_heart;
    logic [30:0] mdl_tol;
    logic [5:0]  mdl_limit;

    // edges waiting to be driven, and roots waiting to be seen
    item_t   edge_q[$];
    result_t root_q[$];

    int errors;
    int idle_pct;      // chance of the sender holding off a cycle
    bit hold_sender;   // pause until every root has arrived
    bit cfg_req;
    logic [CFG_IDX_W-1:0] cfg_req_idx;
    logic [COORD_W-1:0]   cfg_req_data;

    // ---------------- fixed point model ----------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // >>> on a signed longint floors, matching truncation toward minus infinity
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC);
    endfunction

    function automatic longint curve_value(longint x, longint y);
        longint x2, y2, t;
        x2 = fx_mul(x, x);
        y2 = fx_mul(y, y);
        t  = clamp32(clamp32(x2 + y2) - ONE_FX);
        if (!mdl_heart) return t;
        return clamp32(fx_mul(fx_mul(t, t), t) - fx_mul(fx_mul(x2, y2), y));
    endfunction

    function automatic bit below_tol(longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return a < longint'(mdl_tol);
    endfunction

    function automatic result_t bisect_edge(item_t e);
        longint lx, ly, hx, hy, cx, cy, v;
        int steps;
        result_t r;
        lx = e.low_x; ly = e.low_y; hx = e.high_x; hy = e.high_y;
        cx = (lx + hx) >>> 1;
        cy = (ly + hy) >>> 1;
        v = curve_value(cx, cy);
        steps = 0;
        while (!below_tol(v) && steps < mdl_limit) begin
            if (v > 0) begin
                hx = cx; hy = cy;
            end
            else begin
                lx = cx; ly = cy;
            end
            steps++;
            cx = (lx + hx) >>> 1;
            cy = (ly + hy) >>> 1;
            v = curve_value(cx, cy);
        end
        r.root_x = cx[31:0];
        r.root_y = cy[31:0];
        r.converged = below_tol(v);
        r.steps_taken = steps[5:0];
        r.batch_end = e.last_edge;
        return r;
    endfunction

    // ---------------- clock, reset, timeout ----------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------- driver ----------------
    // a fresh edge is only offered when start was low or the last beat was just taken,
    // so start never drops and rises in the same step
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            item  <= '0;
        end
        else begin
            if (start && !busy) begin
                root_q.push_back(bisect_edge(item));
            end
            if (start && busy) begin
                // hold the beat until it is taken
            end
            else if (edge_q.size() > 0 && !hold_sender &&
                     $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                item  <= edge_q.pop_front();
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // configuration channel, one beat per request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            cfg_valid <= 1'b0;
        end
        else if (cfg_req && !cfg_valid) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_req_idx;
            cfg_data  <= cfg_req_data;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (root_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected root beat: %p", result);
            end
            else begin
                result_t exp_r;
                exp_r = root_q.pop_front();
                if (result.root_x !== exp_r.root_x || result.root_y !== exp_r.root_y ||
                    result.converged !== exp_r.converged ||
                    result.steps_taken !== exp_r.steps_taken ||
                    result.batch_end !== exp_r.batch_end) begin
                    errors++;
                    if (errors <= 10)
                        $display("root mismatch: expected %p, got %p", exp_r, result);
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_req_idx  = idx;
        cfg_req_data = val;
        cfg_req = 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        cfg_req = 1'b0;
        case (idx)
            CFG_CURVE_KIND: mdl_heart = val[0];
            CFG_TOLERANCE:  mdl_tol   = val[30:0];
            CFG_ITER_LIMIT: mdl_limit = val[5:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // every edge yields a root, so an empty expectation queue means idle
    task automatic drain;
        while (edge_q.size() > 0 || start || busy || root_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_edge(int lx, int ly, int hx, int hy, bit last);
        item_t e;
        e.low_x = lx; e.low_y = ly; e.high_x = hx; e.high_y = hy;
        e.last_edge = last;
        edge_q.push_back(e);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return $urandom;                                  // full range
            1: return int'($urandom_range(0, 2 * 33554432)) - 33554432;
            default: return int'($urandom_range(0, 4 * 16777216)) - 2 * 16777216;
        endcase
    endfunction

    // mostly well formed crossings: one end inside the curve, one outside
    task automatic add_random_edge;
        int ang_x, ang_y;
        if ($urandom_range(9) < 2) begin
            add_edge(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(1));
        end
        else begin
            ang_x = int'($urandom_range(0, 2 * 12000000)) - 12000000;
            ang_y = int'($urandom_range(0, 2 * 12000000)) - 12000000;
            add_edge(ang_x / 4, ang_y / 4, ang_x * 2, ang_y * 2, $urandom_range(1));
        end
    endtask

    task automatic random_phase(int n, int idle);
        idle_pct = idle;
        repeat (n) add_random_edge();
        drain();
    endtask

    // ---------------- main sequence ----------------
    initial begin
        errors = 0;
        idle_pct = 0;
        hold_sender = 1'b0;
        cfg_req = 1'b0;
        cfg_req_idx = '0;
        cfg_req_data = '0;
        mdl_heart = 1'b0;
        mdl_tol = 31'd17;
        mdl_limit = 6'd32;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, extremes and non-bracketing ends
        add_edge(0, 0, 32'sh0200_0000, 0, 1'b0);
        add_edge(0, 0, 0, 32'sh0200_0000, 1'b1);
        add_edge(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        add_edge(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
        add_edge(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        add_edge(32'sh0300_0000, 0, 32'sh0400_0000, 0, 1'b0);
        add_edge(0, 0, 0, 0, 1'b1);
        add_edge(-1, -1, -1, -1, 1'b0);
        drain();

        // limit zero: only the first midpoint
        write_reg(CFG_ITER_LIMIT, 32'd0);
        add_edge(0, 0, 32'sh0200_0000, 0, 1'b0);
        add_edge(0, 0, 32'sh0100_0000, 0, 1'b1);
        drain();

        // tolerance zero, heart, longest search
        write_reg(CFG_TOLERANCE, 32'd0);
        write_reg(CFG_ITER_LIMIT, 32'd63);
        write_reg(CFG_CURVE_KIND, 32'd1);
        add_edge(0, 0, 32'sh0200_0000, 32'sh0100_0000, 1'b0);
        add_edge(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
        drain();

        // widest tolerance: converges at once
        write_reg(CFG_TOLERANCE, 32'h7fff_ffff);
        add_edge(0, 0, 32'sh0200_0000, 0, 1'b1);
        add_edge(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 1'b0);
        drain();

        // random phases with varied settings and idling
        write_reg(CFG_CURVE_KIND, 32'd0);
        write_reg(CFG_TOLERANCE, 32'd17);
        write_reg(CFG_ITER_LIMIT, 32'd32);
        random_phase(130, 0);

        write_reg(CFG_CURVE_KIND, 32'd1);
        write_reg(CFG_TOLERANCE, 32'd4096);
        random_phase(130, 62);

        // pause with work in flight until every root has come back
        idle_pct = 0;
        repeat (20) add_random_edge();
        repeat (40) @(posedge clk);
        hold_sender = 1'b1;
        while (busy || start || root_q.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        write_reg(CFG_ITER_LIMIT, 32'd1);
        write_reg(CFG_TOLERANCE, $urandom & 32'h0000_ffff);
        random_phase(130, 11);

        write_reg(CFG_CURVE_KIND, 32'd0);
        write_reg(CFG_ITER_LIMIT, $urandom_range(1, 63));
        write_reg(CFG_TOLERANCE, $urandom_range(1, 200));
        random_phase(120, 62);

        write_reg(CFG_ITER_LIMIT, 32'd63);
        random_phase(100, 0);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== implicit_curve_bisection_root.f =====
src/icbr_pkg.sv
src/icbr_mul_cell.sv
src/icbr_eval.sv
src/implicit_curve_bisection_root.sv
tb/implicit_curve_bisection_root_test.sv
